// File: hw/rtl/bffa_pkg.sv
package bffa_pkg;

    // Field widths fixed by the interface
    localparam int IDX_W    = 14;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 32;
    localparam int CFG_AW   = 3;

    // Bitmap word geometry
    localparam int WORD_W   = 64;
    localparam int WORD_LOG = 6;

    // Reset value of the pool size register
    localparam logic [IDX_W-1:0] POOL_SIZE_RESET = 14'd8192;

    // Register map
    localparam logic [CFG_AW-1:0] REG_POOL_SIZE = 3'd0;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK           = 2'd0,
        STAT_FULL         = 2'd1,
        STAT_RANGE        = 2'd2,
        STAT_ALREADY_FREE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_FREE_RD,
        S_FREE_CHK,
        S_DONE
    } t_state;

    // Position of the lowest set bit of a bitmap word
    function automatic logic [WORD_LOG-1:0] lowest_one(input logic [WORD_W-1:0] w);
        logic [WORD_LOG-1:0] p;
        p = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                p = WORD_LOG'(i);
            end
        end
        return p;
    endfunction

endpackage

// File: hw/rtl/bffa_ram.sv
module bffa_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/bitmap_first_free_allocator.sv
// Channel  | Beat qualifier                  | Payload
// ---------+---------------------------------+----------------------------------------------
// in       | i_in_valid  & !o_in_stall       | i_action, i_entry_number
// out      | o_out_valid & !i_out_stall      | o_result_number, o_status, o_free_count
// config   | psel & penable & pwrite         | paddr, pwdata (pool_size at address 0)
//
// Allocate: one bitmap word per cycle through the single word checker, which checks each
// word while the next is read, until a hit or a full verdict at the last word of the pool.
// Free: read the word, then check and write it back, then the result; out-of-range free
// or allocate on an empty pool goes straight to the result. Reset starts a clearing pass
// over every bitmap word (128 at the default) with o_in_stall high. A stalled result does
// not block the next input beat; the result after it waits in the sequencer until the output register frees.
module bitmap_first_free_allocator #(
    parameter int POOL_ENTRIES = 8192
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_action,
    input  logic [bffa_pkg::IDX_W-1:0]            i_entry_number,
    // Result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [bffa_pkg::IDX_W-1:0]            o_result_number,
    output logic [bffa_pkg::STATUS_W-1:0]         o_status,
    output logic [bffa_pkg::IDX_W-1:0]            o_free_count,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bffa_pkg::CFG_AW-1:0]           paddr,
    input  logic [bffa_pkg::CFG_W-1:0]            pwdata,
    output logic [bffa_pkg::CFG_W-1:0]            prdata,
    output logic                                  pready
);

    localparam int WW     = bffa_pkg::WORD_W;
    localparam int WL     = bffa_pkg::WORD_LOG;
    localparam int IW     = bffa_pkg::IDX_W;
    localparam int DEPTH  = (POOL_ENTRIES + WW - 1) / WW;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [16:0] CAP = 17'(POOL_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    bffa_pkg::t_state  r_state, n_state;
    bffa_pkg::t_status r_stat, n_stat;

    logic [IW-1:0]       r_pool_size;
    logic [AW-1:0]       r_scan_addr, n_scan_addr;
    logic                r_chk_valid, n_chk_valid;
    logic [AW-1:0]       r_chk_addr, n_chk_addr;
    logic [IW-1:0]       r_index, n_index;
    logic [IW-1:0]       r_res, n_res;
    logic [IW-1:0]       r_alloc_cnt, n_alloc_cnt;
    logic                r_out_valid, n_out_valid;
    logic [IW-1:0]       r_out_number, n_out_number;
    logic [bffa_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [IW-1:0]       r_out_free, n_out_free;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [WW-1:0]       ram_rdata;

    logic [IW-1:0]       eff_size;
    logic [IW-1:0]       eff_m1;
    logic [AW-1:0]       last_word;
    logic [WW-1:0]       tail_mask;
    logic [WW-1:0]       word_mask;
    logic [WW-1:0]       avail;
    logic [WL-1:0]       avail_pos;
    logic [WW-1:0]       free_bit;
    logic                cfg_wr;
    logic                load_ok;

    // Bitmap storage
    bffa_ram #(
        .WIDTH  (WW),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // Effective pool size and the geometry of its last word
    assign eff_size  = ({3'b000, r_pool_size} > CAP) ? IW'(POOL_ENTRIES) : r_pool_size;
    assign eff_m1    = eff_size - 1'b1;
    assign last_word = AW'(eff_m1 >> WL);
    assign tail_mask = ~({WW{1'b1}} << ({1'b0, eff_m1[WL-1:0]} + 1'b1));
    assign word_mask = (r_chk_addr == last_word) ? tail_mask : {WW{1'b1}};

    // Word checker: lowest clear in-range bit of the word just read
    assign avail     = ~ram_rdata & word_mask;
    assign avail_pos = bffa_pkg::lowest_one(avail);
    assign free_bit  = {{(WW - 1){1'b0}}, 1'b1} << r_index[WL-1:0];

    // Configuration port
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr == bffa_pkg::REG_POOL_SIZE);
    assign pready = 1'b1;
    assign prdata = (paddr == bffa_pkg::REG_POOL_SIZE) ?
                    {{(bffa_pkg::CFG_W - IW){1'b0}}, r_pool_size} : '0;

    assign load_ok = !r_out_valid || !i_out_stall;

    // Sequencer: next state, bitmap access and result assembly
    always_comb begin
        n_state      = r_state;
        n_stat       = r_stat;
        n_scan_addr  = r_scan_addr;
        n_chk_valid  = r_chk_valid;
        n_chk_addr   = r_chk_addr;
        n_index      = r_index;
        n_res        = r_res;
        n_alloc_cnt  = r_alloc_cnt;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_number = r_out_number;
        n_out_status = r_out_status;
        n_out_free   = r_out_free;
        ram_we       = 1'b0;
        ram_waddr    = r_scan_addr;
        ram_wdata    = '0;
        ram_raddr    = r_scan_addr;
        o_in_stall   = 1'b1;

        unique case (r_state)
            bffa_pkg::S_CLEAR: begin
                // Zero one word per cycle
                ram_we      = 1'b1;
                ram_waddr   = r_scan_addr;
                n_scan_addr = r_scan_addr + 1'b1;
                if (r_scan_addr == LAST_ADDR) begin
                    n_scan_addr = '0;
                    n_state     = bffa_pkg::S_IDLE;
                end
            end
            bffa_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_res       = '0;
                    n_stat      = bffa_pkg::STAT_OK;
                    n_scan_addr = '0;
                    n_chk_valid = 1'b0;
                    n_index     = i_entry_number - 1'b1;
                    if (!i_action) begin
                        if (eff_size == '0) begin
                            n_stat  = bffa_pkg::STAT_FULL;
                            n_state = bffa_pkg::S_DONE;
                        end else begin
                            n_state = bffa_pkg::S_ALLOC;
                        end
                    end else if (i_entry_number == '0 || i_entry_number > eff_size) begin
                        n_stat  = bffa_pkg::STAT_RANGE;
                        n_state = bffa_pkg::S_DONE;
                    end else begin
                        n_state = bffa_pkg::S_FREE_RD;
                    end
                end
            end
            bffa_pkg::S_ALLOC: begin
                // Issue the next read while checking the previous word
                ram_raddr   = r_scan_addr;
                n_scan_addr = r_scan_addr + 1'b1;
                n_chk_addr  = r_scan_addr;
                n_chk_valid = 1'b1;
                if (r_chk_valid) begin
                    if (|avail) begin
                        ram_we      = 1'b1;
                        ram_waddr   = r_chk_addr;
                        ram_wdata   = ram_rdata | ({{(WW - 1){1'b0}}, 1'b1} << avail_pos);
                        n_res       = IW'({r_chk_addr, avail_pos}) + 1'b1;
                        n_alloc_cnt = r_alloc_cnt + 1'b1;
                        n_state     = bffa_pkg::S_DONE;
                    end else if (r_chk_addr == last_word) begin
                        n_stat  = bffa_pkg::STAT_FULL;
                        n_state = bffa_pkg::S_DONE;
                    end
                end
            end
            bffa_pkg::S_FREE_RD: begin
                ram_raddr = AW'(r_index >> WL);
                n_state   = bffa_pkg::S_FREE_CHK;
            end
            bffa_pkg::S_FREE_CHK: begin
                // Clear the bit if it is set, else flag a double free
                if ((ram_rdata & free_bit) == '0) begin
                    n_stat = bffa_pkg::STAT_ALREADY_FREE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_index >> WL);
                    ram_wdata = ram_rdata & ~free_bit;
                    if (r_alloc_cnt != '0) begin
                        n_alloc_cnt = r_alloc_cnt - 1'b1;
                    end
                end
                n_state = bffa_pkg::S_DONE;
            end
            bffa_pkg::S_DONE: begin
                // Hand the result to the output register once it is free
                if (load_ok) begin
                    n_out_valid  = 1'b1;
                    n_out_number = r_res;
                    n_out_status = r_stat;
                    n_out_free   = (eff_size > r_alloc_cnt) ? (eff_size - r_alloc_cnt) : '0;
                    n_state      = bffa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bffa_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bffa_pkg::S_CLEAR;
            r_scan_addr <= '0;
            r_chk_valid <= 1'b0;
            r_alloc_cnt <= '0;
            r_out_valid <= 1'b0;
            r_pool_size <= bffa_pkg::POOL_SIZE_RESET;
        end else begin
            r_state     <= n_state;
            r_scan_addr <= n_scan_addr;
            r_chk_valid <= n_chk_valid;
            r_alloc_cnt <= n_alloc_cnt;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_pool_size <= pwdata[IW-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_stat       <= n_stat;
        r_chk_addr   <= n_chk_addr;
        r_index      <= n_index;
        r_res        <= n_res;
        r_out_number <= n_out_number;
        r_out_status <= n_out_status;
        r_out_free   <= n_out_free;
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_number = r_out_number;
    assign o_status        = r_out_status;
    assign o_free_count    = r_out_free;

endmodule

// File: hw/rtl/bffa_checker.sv
module bffa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [bffa_pkg::IDX_W-1:0]    o_result_number,
    input logic [bffa_pkg::STATUS_W-1:0] o_status,
    input logic [bffa_pkg::IDX_W-1:0]    o_free_count
);

    // Reset starts the clearing pass and empties the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_out_valid))
        else $error("reset did not stall input and drop output");

    // One request at a time: a beat is never followed by another at once
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a request is in progress");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_result_number) && $stable(o_status) &&
             $stable(o_free_count)))
        else $error("stalled result beat changed");

    // Only a successful allocate carries a number
    a_number_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != bffa_pkg::STAT_OK) |-> (o_result_number == '0))
        else $error("failed request returned an entry number");

    // A full pool leaves nothing free
    a_full_no_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == bffa_pkg::STAT_FULL) |-> (o_free_count == '0))
        else $error("pool full reported with free entries");

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_result_number (o_result_number),
    .o_status        (o_status),
    .o_free_count    (o_free_count)
);
